/* rtl/hmap_pkg.sv */
// Package for the Henon map step: constants, the pipeline record and small helpers.
package hmap_pkg;

  // Fraction bits of the Q16.16 input and output words.
  localparam int FRAC = 16;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_COEF_A     = 3'd0,
    CFG_COEF_B     = 3'd1,
    CFG_SINE_POWER = 3'd2,
    CFG_Z_Y_GAIN   = 3'd3,
    CFG_X_Z_GAIN   = 3'd4
  } cfg_idx_t;

  localparam logic signed [31:0] A_DEFAULT = 32'sd91750;
  localparam logic signed [31:0] B_DEFAULT = 32'sd19661;
  localparam logic signed [31:0] POWER_MIN = 32'sd131072;
  localparam logic signed [65:0] ONE_FX    = 66'sd65536;

  // Two pi with 32 fraction bits, the modulus of the sine argument.
  localparam logic [34:0] MOD_M    = 35'h6487ED511;
  localparam logic [35:0] MOD_M2   = {MOD_M, 1'b0};
  localparam logic [17:0] MOD_M_HI = MOD_M[34:17];
  localparam logic [16:0] MOD_M_LO = MOD_M[16:0];
  localparam logic [67:0] RECIP_FULL = (68'd1 << 65) / {33'd0, MOD_M};
  localparam logic [30:0] RECIP      = RECIP_FULL[30:0];

  localparam logic [32:0] TWO_PI_Q30  = 33'h1921FB544;
  localparam logic [32:0] PI_Q30      = 33'h0C90FDAA2;
  localparam logic [32:0] HALF_PI_Q30 = 33'h06487ED51;
  localparam logic [30:0] ONE_Q30     = 31'h40000000;

  // Exact division by the Taylor denominators through a multiply and shift.
  localparam int NTERM = 5;
  localparam logic [32:0] MAG_110 = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
  localparam logic [32:0] MAG_72  = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
  localparam logic [32:0] MAG_42  = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
  localparam logic [32:0] MAG_20  = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
  localparam logic [32:0] MAG_6   = 33'(((64'd1 << 35) + 64'd5) / 64'd6);

  function automatic logic [32:0] hdiv_magic(input int j);
    logic [32:0] m;
    case (j)
      0:       m = MAG_110;
      1:       m = MAG_72;
      2:       m = MAG_42;
      3:       m = MAG_20;
      default: m = MAG_6;
    endcase
    return m;
  endfunction

  function automatic int hdiv_shift(input int j);
    int s;
    case (j)
      0:       s = 39;
      1:       s = 39;
      2:       s = 38;
      3:       s = 37;
      default: s = 35;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Everything one item carries down the pipeline.
  typedef struct packed {
    logic signed [31:0] y;
    logic [31:0] d_mag;
    logic        d_neg;
    logic        a_neg;
    logic [46:0] xx;
    logic [46:0] ax;
    logic [63:0] mb;
    logic [63:0] mk;
    logic [63:0] mx;
    logic        b_neg;
    logic        kz_neg;
    logic        kx_neg;
    logic [61:0] n_mag;
    logic        p_neg;
    logic [63:0] pa_lo;
    logic [46:0] pa_hi;
    logic [63:0] pd_lo;
    logic [47:0] pd_hi;
    logic [59:0] qe;
    logic [45:0] qm_hi;
    logic [44:0] qm_lo;
    logic [36:0] rem;
    logic [32:0] ang;
    logic        s_neg;
    logic [31:0] a2;
    logic [62:0] prod;
    logic [64:0] dp;
    logic signed [49:0] xk_t;
    logic [31:0] xo;
    logic [31:0] yo;
    logic [31:0] zo;
    logic [31:0] dvo;
  } pipe_t;

endpackage

/* rtl/henon_map_iteration_step_top.sv */
// Top level of the Henon map step: a 21-stage fixed-point pipeline.
// One Henon map iteration per item: x' = 1 - a*x*x + y, y' = b*x + z*kz,
// z' = sin(z*p) + x*kx, d' = d*|2*a*x| + 1, all signed Q16.16 and saturated
// to 32 bits. A zero coef_a or coef_b selects 1.4 or 0.3, and sine_power is
// raised to at least 2.0. The block takes one item every cycle unless back
// pressure on out_ready stalls a full pipeline; its depth is set by the
// sine path, which reduces z*p modulo two pi with a reciprocal multiply and
// evaluates a Taylor series to the x^11 term, one multiply per stage.
// Valid bits travel with the data and each stage holds while the one after
// it is full and stalled, so a bubble is squeezed out and back pressure on
// the result channel loses nothing. Configuration writes are always taken
// (cfg_ready is tied high); indexes beyond the five registers are ignored,
// and registers are meant to change only while no item is in flight.
module henon_map_iteration_step_top
  import hmap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x_in,
  input  logic [31:0] in_y_in,
  input  logic [31:0] in_z_in,
  input  logic [31:0] in_deriv_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x_out,
  output logic [31:0] out_y_out,
  output logic [31:0] out_z_out,
  output logic [31:0] out_deriv_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NS = 21;

  logic signed [31:0] coef_a_r, coef_b_r, sine_power_r, kz_r, kx_r;
  logic signed [31:0] a_eff, b_eff, p_eff;
  logic [NS-1:0] vld_r;
  logic [NS:0]   en;
  pipe_t st_r   [NS];
  pipe_t st_nxt [NS];

  // Configuration registers; a write is taken whenever it is offered.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r     <= A_DEFAULT;
      coef_b_r     <= B_DEFAULT;
      sine_power_r <= POWER_MIN;
      kz_r         <= '0;
      kx_r         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COEF_A:     coef_a_r     <= cfg_data;
        CFG_COEF_B:     coef_b_r     <= cfg_data;
        CFG_SINE_POWER: sine_power_r <= cfg_data;
        CFG_Z_Y_GAIN:   kz_r         <= cfg_data;
        CFG_X_Z_GAIN:   kx_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Defaults for a zero coefficient and the lower clamp of the sine power.
  always_comb begin
    a_eff = (coef_a_r == 32'sd0) ? A_DEFAULT : coef_a_r;
    b_eff = (coef_b_r == 32'sd0) ? B_DEFAULT : coef_b_r;
    p_eff = (sine_power_r < POWER_MIN) ? POWER_MIN : sine_power_r;
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];

  always_comb begin
    logic [31:0] x_mag, z_mag, a_mag, b_mag, kz_mag, kx_mag;
    logic [63:0] xxp, axp;
    logic [47:0] two_ax;
    logic signed [49:0] tb, tk, tx, ysum;
    logic [79:0] sa, sd;
    logic signed [65:0] nxv, ndv, zv;
    logic [63:0] qm, remw;
    logic [34:0] r35;
    logic [32:0] av;
    logic [31:0] q_in, q, mul_a, s;
    logic [30:0] t;
    logic [16:0] sr;

    for (int k = 1; k < NS; k++) begin
      st_nxt[k] = st_r[k-1];
    end

    // Stage 0: magnitudes and every product formed straight from the inputs.
    x_mag  = mag32(in_x_in);
    z_mag  = mag32(in_z_in);
    a_mag  = mag32(a_eff);
    b_mag  = mag32(b_eff);
    kz_mag = mag32(kz_r);
    kx_mag = mag32(kx_r);
    xxp    = 64'(x_mag) * 64'(x_mag);
    axp    = 64'(a_mag) * 64'(x_mag);
    st_nxt[0]        = '0;
    st_nxt[0].y      = in_y_in;
    st_nxt[0].d_mag  = mag32(in_deriv_in);
    st_nxt[0].d_neg  = in_deriv_in[31];
    st_nxt[0].a_neg  = a_eff[31];
    st_nxt[0].xx     = xxp[62:16];
    st_nxt[0].ax     = axp[62:16];
    st_nxt[0].mb     = 64'(x_mag) * 64'(b_mag);
    st_nxt[0].b_neg  = in_x_in[31] ^ b_eff[31];
    st_nxt[0].mk     = 64'(z_mag) * 64'(kz_mag);
    st_nxt[0].kz_neg = in_z_in[31] ^ kz_r[31];
    st_nxt[0].mx     = 64'(x_mag) * 64'(kx_mag);
    st_nxt[0].kx_neg = in_x_in[31] ^ kx_r[31];
    st_nxt[0].n_mag  = 62'(64'(z_mag) * 64'(p_eff[30:0]));
    st_nxt[0].p_neg  = in_z_in[31];

    // Stage 1: split wide products, finish y, quotient estimate for the sine.
    two_ax = {st_r[0].ax, 1'b0};
    st_nxt[1].pa_lo = 64'(st_r[0].xx[31:0]) * 64'(a_mag);
    st_nxt[1].pa_hi = 47'(47'(st_r[0].xx[46:32]) * 47'(a_mag));
    st_nxt[1].pd_lo = 64'(two_ax[31:0]) * 64'(st_r[0].d_mag);
    st_nxt[1].pd_hi = 48'(48'(two_ax[47:32]) * 48'(st_r[0].d_mag));
    tb = $signed({2'b00, st_r[0].mb[63:16]});
    tk = $signed({2'b00, st_r[0].mk[63:16]});
    tx = $signed({2'b00, st_r[0].mx[63:16]});
    if (st_r[0].b_neg) tb = -tb;
    if (st_r[0].kz_neg) tk = -tk;
    if (st_r[0].kx_neg) tx = -tx;
    ysum = tb + tk;
    st_nxt[1].yo   = sat32(66'(ysum));
    st_nxt[1].xk_t = tx;
    st_nxt[1].qe   = 60'(st_r[0].n_mag[61:33]) * 60'(RECIP);

    // Stage 2: finish x and the derivative; quotient times modulus in halves.
    sa  = 80'({st_r[1].pa_hi, 32'd0}) + 80'(st_r[1].pa_lo);
    nxv = 66'(st_r[1].y) + ONE_FX;
    if (st_r[1].a_neg) begin
      nxv = nxv + $signed({3'b000, sa[78:16]});
    end else begin
      nxv = nxv - $signed({3'b000, sa[78:16]});
    end
    st_nxt[2].xo = sat32(nxv);
    sd  = 80'({st_r[1].pd_hi, 32'd0}) + 80'(st_r[1].pd_lo);
    ndv = $signed({2'b00, sd[79:16]});
    if (st_r[1].d_neg) ndv = -ndv;
    st_nxt[2].dvo   = sat32(ndv + ONE_FX);
    st_nxt[2].qm_hi = 46'(st_r[1].qe[59:32]) * 46'(MOD_M_HI);
    st_nxt[2].qm_lo = 45'(st_r[1].qe[59:32]) * 45'(MOD_M_LO);

    // Stages 3 to 5: remainder below three moduli, then two corrections.
    qm   = 64'({st_r[2].qm_hi, 17'd0}) + 64'(st_r[2].qm_lo);
    remw = 64'(st_r[2].n_mag) - qm;
    st_nxt[3].rem = remw[36:0];
    if (st_r[3].rem >= 37'(MOD_M2)) st_nxt[4].rem = st_r[3].rem - 37'(MOD_M2);
    if (st_r[4].rem >= 37'(MOD_M))  st_nxt[5].rem = st_r[4].rem - 37'(MOD_M);

    // Stage 6: a negative argument wraps to the positive side, then Q30.
    r35 = st_r[5].rem[34:0];
    if (st_r[5].p_neg && (r35 != 35'd0)) r35 = MOD_M - r35;
    st_nxt[6].ang = r35[34:2];

    // Stages 7 and 8: fold into the first quadrant, keeping the sign.
    av = st_r[6].ang;
    if (av >= TWO_PI_Q30) av = av - TWO_PI_Q30;
    st_nxt[7].s_neg = 1'b0;
    if (av >= PI_Q30) begin
      av = av - PI_Q30;
      st_nxt[7].s_neg = 1'b1;
    end
    st_nxt[7].ang = av;
    if (st_r[7].ang > HALF_PI_Q30) st_nxt[8].ang = PI_Q30 - st_r[7].ang;

    // Stage 9: square of the angle.
    st_nxt[9].prod = 63'(st_r[8].ang[30:0]) * 63'(st_r[8].ang[30:0]);

    // Stages 10 to 19: Horner steps, a divide and then a multiply each.
    for (int j = 0; j < NTERM; j++) begin
      q_in = st_r[9+2*j].prod[61:30];
      if (j == 0) st_nxt[10+2*j].a2 = q_in;
      st_nxt[10+2*j].dp = 65'(q_in) * 65'(hdiv_magic(j));
      q = 32'(st_r[10+2*j].dp >> hdiv_shift(j));
      t = ONE_Q30 - q[30:0];
      mul_a = (j == NTERM - 1) ? {1'b0, st_r[10+2*j].ang[30:0]} : st_r[10+2*j].a2;
      st_nxt[11+2*j].prod = 63'(mul_a) * 63'(t);
    end

    // Stage 20: round the sine to 16 fraction bits and add the x gain term.
    s  = st_r[19].prod[61:30];
    sr = 17'((33'(s) + 33'd8192) >> 14);
    zv = $signed({49'd0, sr});
    if (st_r[19].s_neg) zv = -zv;
    st_nxt[20].xo = st_r[19].xo;
    st_nxt[20].zo = sat32(zv + 66'(st_r[19].xk_t));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) st_r[k] <= st_nxt[k];
    end
  end

  // Every field of a result comes from the last stage.
  assign out_x_out     = st_r[NS-1].xo;
  assign out_y_out     = st_r[NS-1].yo;
  assign out_z_out     = st_r[NS-1].zo;
  assign out_deriv_out = st_r[NS-1].dvo;

`ifndef SYNTHESIS
  a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NS-1] |-> in_ready)
    else $error("input stalled with an empty output stage");
  a_rem_two_m: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (st_r[4].rem < 37'(MOD_M2)))
    else $error("sine argument remainder not below twice the modulus");
  a_rem_m: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (st_r[5].rem < 37'(MOD_M)))
    else $error("sine argument remainder not reduced");
  a_quadrant: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[8] |-> (st_r[8].ang <= HALF_PI_Q30))
    else $error("sine angle not folded into the first quadrant");
`endif

endmodule
